[src/utc_pkg.sv]
package utc_pkg;

    localparam int WIN_BYTES = 40;
    localparam int FILL_W    = 6;
    localparam int OUT_WORDS = 5;

    localparam logic [7:0] SPACE_CHAR = 8'h20;

    typedef struct packed {
        logic load;
        logic apply;
        logic emit;
        logic push;
        logic push_last;
        logic drop;
        logic clr_line;
    } t_cmd;

    typedef struct packed {
        logic q_empty;
        logic stop;
        logic win_full;
        logic fill_zero;
        logic drop_done;
        logic out_busy;
        logic line_end;
    } t_stat;

endpackage

[src/utc_dp.sv]
module utc_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  utc_pkg::t_cmd      i_cmd,
    output utc_pkg::t_stat     o_stat,
    input  logic [7:0]         i_in_byte,
    input  logic               i_line_end,
    input  logic               i_ready,
    output logic               o_valid,
    output logic [63:0]        o_chain_word0,
    output logic [63:0]        o_chain_word1,
    output logic [63:0]        o_chain_word2,
    output logic [63:0]        o_chain_word3,
    output logic [63:0]        o_chain_word4,
    output logic [5:0]         o_chain_length,
    output logic               o_last_chain
);
    import utc_pkg::*;

    logic [7:0]        r_win [WIN_BYTES];
    logic [FILL_W-1:0] r_fill;
    logic              r_tail_sp;
    logic [7:0]        r_q [4];
    logic [2:0]        r_qn;
    logic              r_final;
    logic              r_end;
    logic              r_ignored;

    logic [8*WIN_BYTES-1:0] r_hold;
    logic [FILL_W-1:0]      r_hold_len;
    logic [8*WIN_BYTES-1:0] r_out;
    logic [FILL_W-1:0]      r_out_len;
    logic                   r_out_last;
    logic                   r_out_v;

    // decode of the queue head
    logic [7:0]  b;
    logic [2:0]  need;
    logic        ok;
    logic [20:0] cp;
    logic        kept;
    logic [20:0] lc;
    logic [2:0]  popn;
    logic        cont1, cont2, cont3;

    always_comb begin
        b     = r_q[0];
        cont1 = (r_q[1][7:6] == 2'b10);
        cont2 = (r_q[2][7:6] == 2'b10);
        cont3 = (r_q[3][7:6] == 2'b10);
        if (b < 8'h80)                       need = 3'd1;
        else if (b >= 8'hC2 && b < 8'hE0)    need = 3'd2;
        else if (b >= 8'hE0 && b < 8'hF0)    need = 3'd3;
        else if (b >= 8'hF0 && b < 8'hF5)    need = 3'd4;
        else                                 need = 3'd0;
        case (need)
            3'd1:    cp = {13'd0, b};
            3'd2:    cp = {10'd0, b[4:0], r_q[1][5:0]};
            3'd3:    cp = {5'd0, b[3:0], r_q[1][5:0], r_q[2][5:0]};
            3'd4:    cp = {b[2:0], r_q[1][5:0], r_q[2][5:0], r_q[3][5:0]};
            default: cp = 21'd0;
        endcase
        ok = 1'b1;
        if (need == 3'd0 || r_qn < need) ok = 1'b0;
        if (need >= 3'd2 && !cont1) ok = 1'b0;
        if (need >= 3'd3 && !cont2) ok = 1'b0;
        if (need == 3'd4 && !cont3) ok = 1'b0;
        if (need == 3'd3 && cp < 21'h800) ok = 1'b0;
        if (need == 3'd4 && cp < 21'h10000) ok = 1'b0;
        popn = ok ? need : 3'd1;
        kept = ok && ((cp >= 21'h30 && cp <= 21'h39) || (cp >= 21'h61 && cp <= 21'h7A) ||
                      (cp >= 21'h41 && cp <= 21'h5A) || cp == 21'h27 ||
                      (cp >= 21'h400 && cp <= 21'h52F));
        if (cp >= 21'h41 && cp <= 21'h5A)         lc = cp + 21'h20;
        else if (cp >= 21'h410 && cp <= 21'h42F)  lc = cp + 21'h20;
        else if (cp >= 21'h400 && cp <= 21'h40F)  lc = cp + 21'h50;
        else                                      lc = cp;
    end

    logic [7:0] lead_b, cont_b;
    assign lead_b = 8'hC0 | lc[13:6];
    assign cont_b = {2'b10, lc[5:0]};

    logic [8*WIN_BYTES-1:0] masked;
    always_comb begin
        for (int i = 0; i < WIN_BYTES; i++) begin
            masked[8*i +: 8] = (FILL_W'(i) < r_fill) ? r_win[i] : 8'd0;
        end
    end

    always_comb begin
        o_stat.q_empty   = (r_qn == 3'd0);
        o_stat.stop      = (need != 3'd0) && (r_qn < need) && !r_final;
        o_stat.win_full  = (r_fill >= FILL_W'(WIN_BYTES));
        o_stat.fill_zero = (r_fill == '0);
        o_stat.drop_done = (r_win[0] == SPACE_CHAR) || (r_fill == FILL_W'(1));
        o_stat.out_busy  = r_out_v && !i_ready;
        o_stat.line_end  = r_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_qn      <= '0;
            r_ignored <= 1'b0;
            r_out_v   <= 1'b0;
            r_tail_sp <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_end   <= i_line_end;
                r_final <= i_line_end || (i_in_byte == 8'd0);
                if (!r_ignored) begin
                    if (i_in_byte == 8'd0) begin
                        r_ignored <= 1'b1;
                    end else begin
                        r_q[r_qn[1:0]] <= i_in_byte;
                        r_qn           <= r_qn + 3'd1;
                    end
                end
            end
            if (i_cmd.apply) begin
                for (int i = 0; i < 4; i++) begin
                    if (i + int'(popn) < 4) r_q[i] <= r_q[2'(i + int'(popn))];
                end
                r_qn <= r_qn - popn;
                if (kept) begin
                    if (lc < 21'h80) begin
                        if (r_fill < FILL_W'(WIN_BYTES)) begin
                            r_win[r_fill] <= lc[7:0];
                            r_fill        <= r_fill + 1'b1;
                            r_tail_sp     <= 1'b0;
                        end
                    end else if (r_fill + FILL_W'(2) <= FILL_W'(WIN_BYTES)) begin
                        r_win[r_fill]        <= lead_b;
                        r_win[r_fill + 1'b1] <= cont_b;
                        r_fill               <= r_fill + FILL_W'(2);
                        r_tail_sp            <= 1'b0;
                    end
                end else if (r_fill != '0 && r_fill < FILL_W'(WIN_BYTES) && !r_tail_sp) begin
                    r_win[r_fill] <= SPACE_CHAR;
                    r_fill        <= r_fill + 1'b1;
                    r_tail_sp     <= 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_hold     <= masked;
                r_hold_len <= r_fill;
            end
            if (i_cmd.drop) begin
                for (int i = 0; i < WIN_BYTES - 1; i++) r_win[i] <= r_win[i+1];
                r_fill <= r_fill - 1'b1;
            end
            if (i_cmd.clr_line) begin
                r_qn      <= '0;
                r_ignored <= 1'b0;
            end
            if (i_cmd.push) begin
                r_out      <= r_hold;
                r_out_len  <= r_hold_len;
                r_out_last <= i_cmd.push_last;
                r_out_v    <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_v;
    assign o_chain_word0  = r_out[63:0];
    assign o_chain_word1  = r_out[127:64];
    assign o_chain_word2  = r_out[191:128];
    assign o_chain_word3  = r_out[255:192];
    assign o_chain_word4  = r_out[319:256];
    assign o_chain_length = r_out_len;
    assign o_last_chain   = r_out_last;

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WIN_BYTES)) else $error("window overfilled");
    a_queue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qn <= 3'd4) else $error("decode queue overflow");
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> r_out_len != '0) else $error("empty chain emitted");
    a_no_push_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> !(r_out_v && !i_ready)) else $error("output overwritten");

endmodule

[src/utc_ctrl.sv]
module utc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  utc_pkg::t_stat i_stat,
    output utc_pkg::t_cmd  o_cmd
);
    import utc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DEC, S_EMIT, S_DROP, S_END, S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_hold_v, n_hold_v;
    logic   r_flush, n_flush;

    always_comb begin
        n_state  = r_state;
        n_hold_v = r_hold_v;
        n_flush  = r_flush;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                if (i_stat.q_empty || i_stat.stop) begin
                    n_state = S_END;
                end else if (i_stat.win_full) begin
                    n_flush = 1'b0;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.apply = 1'b1;
                end
            end
            S_EMIT: begin
                if (!(r_hold_v && i_stat.out_busy)) begin
                    o_cmd.push = r_hold_v;
                    o_cmd.emit = 1'b1;
                    n_hold_v   = 1'b1;
                    n_state    = S_DROP;
                end
            end
            S_DROP: begin
                o_cmd.drop = 1'b1;
                if (i_stat.drop_done) n_state = r_flush ? S_END : S_DEC;
            end
            S_END: begin
                if (i_stat.line_end && !i_stat.fill_zero) begin
                    n_flush = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    if (i_stat.line_end) o_cmd.clr_line = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_hold_v) begin
                    n_state = S_IDLE;
                end else if (!i_stat.out_busy) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.push_last = 1'b1;
                    n_hold_v        = 1'b0;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_hold_v <= 1'b0;
            r_flush  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_hold_v <= n_hold_v;
            r_flush  <= n_flush;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    a_hold_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !r_hold_v) else $error("chain held across beats");
    a_emit_then_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> r_state == S_DROP) else $error("emit without drop");
    a_apply_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.apply |-> !i_stat.win_full) else $error("apply on full window");

endmodule

[src/utf8_text_chain_window.sv]
// UTF-8 text to word chains. One byte beat is taken at a time, o_ready being
// high only while the block is idle. A beat passes the accept step, decodes
// the queued characters one after another, finds the queue drained or waiting
// on a partial sequence, passes a closing step and ends in a final step that
// also hands out a chain still held. Each chain emitted while decoding is
// followed by a drop of the window's first word, its space included; the
// window shifts one byte per cycle. A line-end flush emits and drops each
// chain the same way, passing the closing step again after each. A held
// chain waits while the output register is still full. Output chains leave
// through a registered stage; the beat's last chain is marked with o_last_chain.
module utf8_text_chain_window (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_line_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_chain_word0,
    output logic [63:0] o_chain_word1,
    output logic [63:0] o_chain_word2,
    output logic [63:0] o_chain_word3,
    output logic [63:0] o_chain_word4,
    output logic [5:0]  o_chain_length,
    output logic        o_last_chain
);
    import utc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    utc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    utc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_in_byte      (i_in_byte),
        .i_line_end     (i_line_end),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_chain_word0  (o_chain_word0),
        .o_chain_word1  (o_chain_word1),
        .o_chain_word2  (o_chain_word2),
        .o_chain_word3  (o_chain_word3),
        .o_chain_word4  (o_chain_word4),
        .o_chain_length (o_chain_length),
        .o_last_chain   (o_last_chain)
    );

endmodule
